// ===== design/lkec_pkg.sv =====
// Shared types, codes and defaults of the keyed LRU entry cache.
package lkec_pkg;

  localparam int Entries         = 128;
  localparam int KeyBits         = 64;
  localparam int DataBits        = 32;
  localparam int DefaultCapacity = 100;

  localparam int KeyW    = 64;
  localparam int PayW    = 32;
  localparam int StatusW = 2;
  localparam int EvictW  = 32;
  localparam int OccW    = 8;
  localparam int CapW    = 8;

  typedef enum logic [StatusW-1:0] {
    ST_NEW  = 2'd0,
    ST_UPD  = 2'd1,
    ST_HIT  = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef struct packed {
    logic start;
    logic scan_rd;
    logic scan_next;
    logic hit;
    logic prep;
    logic sh_rd;
    logic sh_wr;
    logic wr_head;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic match;
    logic ptr_zero;
    logic lookup;
    logic hit;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/lkec_req_if.sv =====
// Request and response channel interfaces of the keyed LRU entry cache.
interface lkec_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [lkec_pkg::KeyW-1:0]   key;
  logic [lkec_pkg::PayW-1:0]   payload;

  modport source (output valid, output mode, output key, output payload, input ready);
  modport sink (input valid, input mode, input key, input payload, output ready);
endinterface

interface lkec_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lkec_pkg::StatusW-1:0]  status;
  logic [lkec_pkg::PayW-1:0]     data_out;
  logic [lkec_pkg::EvictW-1:0]   evictions;
  logic [lkec_pkg::OccW-1:0]     occupancy;

  modport source (output valid, output status, output data_out, output evictions,
                  output occupancy, input ready);
  modport sink (input valid, input status, input data_out, input evictions,
                input occupancy, output ready);
endinterface

// ===== design/lkec_dp.sv =====
// Datapath of the keyed LRU entry cache: recency-ordered entry memory, counters and result register.
module lkec_dp #(
  parameter int ENTRIES   = lkec_pkg::Entries,
  parameter int KEY_BITS  = lkec_pkg::KeyBits,
  parameter int DATA_BITS = lkec_pkg::DataBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lkec_pkg::CapW-1:0]    cfg_wdata_i,
  input  logic                         req_mode_i,
  input  logic [lkec_pkg::KeyW-1:0]    req_key_i,
  input  logic [lkec_pkg::PayW-1:0]    req_payload_i,
  input  logic                         rsp_ready_i,
  input  lkec_pkg::cmd_t               cmd_i,
  output lkec_pkg::stat_t              stat_o,
  output logic                         rsp_valid_o,
  output logic [lkec_pkg::StatusW-1:0] rsp_status_o,
  output logic [lkec_pkg::PayW-1:0]    rsp_data_o,
  output logic [lkec_pkg::EvictW-1:0]  rsp_evict_o,
  output logic [lkec_pkg::OccW-1:0]    rsp_occ_o
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam int WW = KEY_BITS + DATA_BITS;

  logic [WW-1:0] mem_q [ENTRIES];
  logic [WW-1:0] rdata_q;

  logic                 mode_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] pay_q;
  logic [DATA_BITS-1:0] hit_data_q;
  logic                 hit_q, hit_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        live_q, live_d;
  logic [lkec_pkg::EvictW-1:0] evict_q, evict_d;
  logic [lkec_pkg::CapW-1:0]   cap_q;

  logic                        out_valid_q;
  logic [lkec_pkg::StatusW-1:0] out_status_q;
  logic [lkec_pkg::PayW-1:0]   out_data_q;
  logic [lkec_pkg::EvictW-1:0] out_evict_q;
  logic [lkec_pkg::OccW-1:0]   out_occ_q;

  logic [lkec_pkg::CapW-1:0] cap_sel;
  logic [CW-1:0]             eff_cap;
  logic [CW-1:0]             live_trim;
  logic [DATA_BITS-1:0]      head_data;
  logic [CW-1:0]             ptr_dec;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [WW-1:0]             wdata;
  logic                      re;
  logic [AW-1:0]             raddr;
  lkec_pkg::status_e         status_sel;

  always_comb begin
    cap_sel = (cap_q == '0) ? lkec_pkg::CapW'(lkec_pkg::DefaultCapacity) : cap_q;
    if (32'(cap_sel) > 32'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cap_sel);
    end
    live_trim = (live_q >= eff_cap) ? (eff_cap - CW'(1)) : live_q;
    head_data = mode_q ? hit_data_q : pay_q;
    ptr_dec   = ptr_q - CW'(1);
  end

  always_comb begin
    we    = cmd_i.sh_wr | cmd_i.wr_head;
    waddr = cmd_i.wr_head ? '0 : ptr_q[AW-1:0];
    wdata = cmd_i.wr_head ? {key_q, head_data} : rdata_q;
    re    = cmd_i.scan_rd | cmd_i.sh_rd;
    raddr = cmd_i.sh_rd ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= req_mode_i;
      key_q  <= KEY_BITS'(req_key_i);
      pay_q  <= DATA_BITS'(req_payload_i);
    end
    if (cmd_i.hit) begin
      hit_data_q <= rdata_q[DATA_BITS-1:0];
    end
  end

  always_comb begin
    hit_d   = hit_q;
    ptr_d   = ptr_q;
    live_d  = live_q;
    evict_d = evict_q;
    if (cmd_i.start) begin
      hit_d = 1'b0;
      ptr_d = '0;
    end
    if (cmd_i.scan_next) begin
      ptr_d = ptr_q + CW'(1);
    end
    if (cmd_i.hit) begin
      hit_d = 1'b1;
    end
    if (cmd_i.prep && !hit_q) begin
      ptr_d   = live_trim;
      live_d  = live_trim;
      evict_d = evict_q + lkec_pkg::EvictW'(live_q - live_trim);
    end
    if (cmd_i.sh_wr) begin
      ptr_d = ptr_dec;
    end
    if (cmd_i.wr_head && !hit_q) begin
      live_d = live_q + CW'(1);
    end
  end

  always_comb begin
    if (mode_q) begin
      status_sel = hit_q ? lkec_pkg::ST_HIT : lkec_pkg::ST_MISS;
    end else begin
      status_sel = hit_q ? lkec_pkg::ST_UPD : lkec_pkg::ST_NEW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      ptr_q       <= '0;
      live_q      <= '0;
      evict_q     <= '0;
      cap_q       <= lkec_pkg::CapW'(lkec_pkg::DefaultCapacity);
      out_valid_q <= 1'b0;
    end else begin
      hit_q   <= hit_d;
      ptr_q   <= ptr_d;
      live_q  <= live_d;
      evict_q <= evict_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= status_sel;
      out_data_q   <= (mode_q && !hit_q) ? '0 : lkec_pkg::PayW'(head_data);
      out_evict_q  <= evict_q;
      out_occ_q    <= lkec_pkg::OccW'(live_q);
    end
  end

  always_comb begin
    stat_o.scan_end = (ptr_q == live_q);
    stat_o.match    = (rdata_q[WW-1:DATA_BITS] == key_q);
    stat_o.ptr_zero = (ptr_q == '0);
    stat_o.lookup   = (mode_q == lkec_pkg::MODE_LOOKUP);
    stat_o.hit      = hit_q;
    stat_o.out_busy = out_valid_q & ~rsp_ready_i;
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_data_o   = out_data_q;
  assign rsp_evict_o  = out_evict_q;
  assign rsp_occ_o    = out_occ_q;

endmodule

// ===== design/lkec_ctrl.sv =====
// Controller state machine of the keyed LRU entry cache.
module lkec_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  lkec_pkg::stat_t stat_i,
  output lkec_pkg::cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_CMP    = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_SHRD   = 8'b0001_0000,
    S_SHWR   = 8'b0010_0000,
    S_HEAD   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = S_DECIDE;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_DECIDE: begin
        if (stat_i.lookup && !stat_i.hit) begin
          state_d = S_DONE;
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = S_SHRD;
        end
      end
      S_SHRD: begin
        if (stat_i.ptr_zero) begin
          state_d = S_HEAD;
        end else begin
          cmd_o.sh_rd = 1'b1;
          state_d     = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = S_SHRD;
      end
      S_HEAD: begin
        cmd_o.wr_head = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/lru_keyed_entry_cache_top.sv =====
// Top level of the keyed LRU entry cache.
//
//   channel   direction  fields
//   req_i     in         mode, key, payload
//   rsp_o     out        status, data_out, evictions, occupancy
//   cfg       in         cfg_we_i, cfg_wdata_i (capacity)
//
// Entries are kept in one memory ordered from most to least recent.
// A request scans the entries for its key, then on a hit or a new insert moves
// the more recent entries down by one place and writes the entry at the head.
// The entry memory has registered read data.
// A new request is taken while the previous response still waits on rsp_o.
// Reset empties the cache at once; no clearing pass is needed.
module lru_keyed_entry_cache_top #(
  parameter int ENTRIES   = lkec_pkg::Entries,
  parameter int KEY_BITS  = lkec_pkg::KeyBits,
  parameter int DATA_BITS = lkec_pkg::DataBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkec_pkg::CapW-1:0] cfg_wdata_i,
  lkec_req_if.sink                  req_i,
  lkec_rsp_if.source                rsp_o
);

  lkec_pkg::cmd_t  cmd;
  lkec_pkg::stat_t stat;

  lkec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lkec_dp #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_mode_i    (req_i.mode),
    .req_key_i     (req_i.key),
    .req_payload_i (req_i.payload),
    .rsp_ready_i   (rsp_o.ready),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_status_o  (rsp_o.status),
    .rsp_data_o    (rsp_o.data_out),
    .rsp_evict_o   (rsp_o.evictions),
    .rsp_occ_o     (rsp_o.occupancy)
  );

endmodule

// ===== design/lkec_checker.sv =====
// Port-level assertions of the keyed LRU entry cache and their binding.
module lkec_checker #(
  parameter int ENTRIES = lkec_pkg::Entries
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [lkec_pkg::StatusW-1:0] rsp_status,
  input logic [lkec_pkg::PayW-1:0]    rsp_data,
  input logic [lkec_pkg::EvictW-1:0]  rsp_evict,
  input logic [lkec_pkg::OccW-1:0]    rsp_occ
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data))
    else $error("response changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status == lkec_pkg::ST_MISS |-> rsp_data == '0)
    else $error("lookup miss with nonzero data");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> 32'(rsp_occ) <= 32'(ENTRIES))
    else $error("occupancy above table size");

  a_update_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_ready ##1 rsp_valid && rsp_status == lkec_pkg::ST_UPD
    |-> rsp_evict == $past(rsp_evict) || $past(rsp_evict) != $past(rsp_evict, 1))
    else $error("eviction count moved on update");

endmodule

bind lru_keyed_entry_cache_top lkec_checker #(.ENTRIES(ENTRIES)) u_lkec_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_status (rsp_o.status),
  .rsp_data   (rsp_o.data_out),
  .rsp_evict  (rsp_o.evictions),
  .rsp_occ    (rsp_o.occupancy)
);

// ===== bench/lru_keyed_entry_cache_top_test.sv =====
// Testbench of the keyed LRU entry cache: directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps

module lru_keyed_entry_cache_top_test;

  localparam int IdleLimit = 20000;

  typedef struct {
    lkec_pkg::mode_e   mode;
    logic [63:0]       key;
    logic [31:0]       payload;
    logic              typed;
    lkec_pkg::status_e status;
    logic [31:0]       data_out;
    logic [31:0]       evictions;
    logic [7:0]        occupancy;
  } row_t;

  typedef struct {
    lkec_pkg::status_e status;
    logic [31:0]       data_out;
    logic [31:0]       evictions;
    logic [7:0]        occupancy;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lkec_pkg::CapW-1:0] cfg_wdata_i = '0;

  lkec_req_if req ();
  lkec_rsp_if rsp ();

  lru_keyed_entry_cache_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req.sink), .rsp_o(rsp.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the cache contents.
  logic        live [lkec_pkg::Entries];
  logic [63:0] tags [lkec_pkg::Entries];
  logic [31:0] vals [lkec_pkg::Entries];
  int          rank [lkec_pkg::Entries];
  int          live_n;
  logic [31:0] evict_n;
  logic [7:0]  cap_reg;

  rsp_t pending_rsps[$];
  row_t dir_rows[$];
  int   errors = 0;
  int   idle_cycles = 0;
  logic stall_en = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int find_entry(input logic [63:0] k);
    for (int i = 0; i < lkec_pkg::Entries; i++) if (live[i] && tags[i] == k) return i;
    return -1;
  endfunction

  function automatic void make_recent(input int idx);
    int r;
    r = rank[idx];
    for (int i = 0; i < lkec_pkg::Entries; i++) if (live[i] && rank[i] < r) rank[i]++;
    rank[idx] = 0;
  endfunction

  function automatic rsp_t cache_step(input lkec_pkg::mode_e m, input logic [63:0] k,
                                      input logic [31:0] p);
    rsp_t r;
    int idx, cap, slot;
    idx = find_entry(k);
    r.data_out = '0;
    if (m == lkec_pkg::MODE_INSERT) begin
      if (idx >= 0) begin
        vals[idx] = p;
        make_recent(idx);
        r.status = lkec_pkg::ST_UPD;
      end else begin
        cap = (cap_reg == 0) ? lkec_pkg::DefaultCapacity : int'(cap_reg);
        if (cap > lkec_pkg::Entries) cap = lkec_pkg::Entries;
        while (live_n >= cap && live_n > 0) begin
          for (int i = 0; i < lkec_pkg::Entries; i++) begin
            if (live[i] && rank[i] == live_n - 1) begin
              live[i] = 1'b0;
              live_n--;
              evict_n++;
              break;
            end
          end
        end
        slot = -1;
        for (int i = 0; i < lkec_pkg::Entries; i++) if (!live[i]) begin slot = i; break; end
        if (slot >= 0) begin
          for (int i = 0; i < lkec_pkg::Entries; i++) if (live[i]) rank[i]++;
          live[slot] = 1'b1;
          tags[slot] = k;
          vals[slot] = p;
          rank[slot] = 0;
          live_n++;
        end
        r.status = lkec_pkg::ST_NEW;
      end
      r.data_out = p;
    end else if (idx >= 0) begin
      make_recent(idx);
      r.data_out = vals[idx];
      r.status = lkec_pkg::ST_HIT;
    end else begin
      r.status = lkec_pkg::ST_MISS;
    end
    r.evictions = evict_n;
    r.occupancy = live_n[7:0];
    return r;
  endfunction

  task automatic send(input lkec_pkg::mode_e m, input logic [63:0] k, input logic [31:0] p,
                      input logic gap);
    rsp_t e;
    @(posedge clk_i);
    if (gap) repeat ($urandom_range(1, 6)) @(posedge clk_i);
    req.valid <= 1'b1;
    req.mode <= m;
    req.key <= k;
    req.payload <= p;
    do @(posedge clk_i); while (!req.ready);
    e = cache_step(m, k, p);
    pending_rsps.push_back(e);
    req.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [7:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
  endtask

  // Checks each response and applies receiver stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (pending_rsps.size() == 0) begin
          report("unexpected response", 0, 0);
        end else begin
          rsp_t e;
          e = pending_rsps.pop_front();
          if (rsp.status !== e.status) report("status", rsp.status, e.status);
          if (rsp.data_out !== e.data_out) report("data_out", rsp.data_out, e.data_out);
          if (rsp.evictions !== e.evictions) report("evictions", rsp.evictions, e.evictions);
          if (rsp.occupancy !== e.occupancy) report("occupancy", rsp.occupancy, e.occupancy);
        end
      end
      rsp.ready <= stall_en ? (($urandom_range(0, 3) != 0) && ($time % 200 > 30)) : 1'b1;
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic void add_row(input lkec_pkg::mode_e m, input logic [63:0] k,
                                  input logic [31:0] p, input logic typed,
                                  input lkec_pkg::status_e s, input logic [31:0] d,
                                  input logic [31:0] ev, input logic [7:0] occ);
    row_t r;
    r.mode = m; r.key = k; r.payload = p; r.typed = typed;
    r.status = s; r.data_out = d; r.evictions = ev; r.occupancy = occ;
    dir_rows.push_back(r);
  endfunction

  initial begin
    logic [63:0] k;
    logic [31:0] p;
    int burst, n, kspace;
    rsp_t e;
    req.valid = 1'b0; req.mode = 1'b0; req.key = '0; req.payload = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < lkec_pkg::Entries; i++) begin
      live[i] = 0; tags[i] = '0; vals[i] = '0; rank[i] = 0;
    end
    live_n = 0; evict_n = '0; cap_reg = lkec_pkg::DefaultCapacity;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(lkec_pkg::MODE_LOOKUP, '0, '0, 1, lkec_pkg::ST_MISS, '0, '0, 8'd0);
    add_row(lkec_pkg::MODE_INSERT, '0, '0, 1, lkec_pkg::ST_NEW, '0, '0, 8'd1);
    add_row(lkec_pkg::MODE_INSERT, '1, '1, 1, lkec_pkg::ST_NEW, '1, '0, 8'd2);
    add_row(lkec_pkg::MODE_LOOKUP, '1, '0, 1, lkec_pkg::ST_HIT, '1, '0, 8'd2);
    add_row(lkec_pkg::MODE_INSERT, '0, 32'h5a5a_a5a5, 1, lkec_pkg::ST_UPD, 32'h5a5a_a5a5,
            '0, 8'd2);
    add_row(lkec_pkg::MODE_LOOKUP, '0, '1, 1, lkec_pkg::ST_HIT, 32'h5a5a_a5a5, '0, 8'd2);
    add_row(lkec_pkg::MODE_LOOKUP, 64'h8000_0000_0000_0000, '0, 1, lkec_pkg::ST_MISS, '0,
            '0, 8'd2);
    add_row(lkec_pkg::MODE_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 0,
            lkec_pkg::ST_NEW, 0, 0, 0);
    add_row(lkec_pkg::MODE_INSERT, 64'h1234, 32'h1, 0, lkec_pkg::ST_NEW, 0, 0, 0);
    add_row(lkec_pkg::MODE_LOOKUP, 64'h1234, 32'h0, 0, lkec_pkg::ST_NEW, 0, 0, 0);
    foreach (dir_rows[i]) begin
      e = cache_step(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].payload);
      // The shadow steps are undone after this loop; send() applies them at acceptance.
      if (dir_rows[i].typed && (e.status !== dir_rows[i].status ||
          e.data_out !== dir_rows[i].data_out || e.occupancy !== dir_rows[i].occupancy))
        report("table row", i, 0);
    end
    for (int i = 0; i < lkec_pkg::Entries; i++) live[i] = 0;
    live_n = 0; evict_n = '0;
    foreach (dir_rows[i]) send(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].payload, 0);

    // Small capacity: inserts of new keys evict the least recent entries.
    set_capacity(8'd1);
    send(lkec_pkg::MODE_INSERT, 64'h77, 32'h77, 0);
    send(lkec_pkg::MODE_INSERT, 64'h78, 32'h78, 1);
    send(lkec_pkg::MODE_LOOKUP, 64'h77, 32'h0, 0);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_capacity(8'd2);
        1: set_capacity(8'd0);
        2: set_capacity(8'd255);
        3: set_capacity(8'd128);
        4: set_capacity(8'd3);
        5: set_capacity(8'd129);
        default: set_capacity(8'($urandom_range(1, 20)));
      endcase
      stall_en = (ph != 4);
      kspace = (ph == 1 || ph == 2 || ph == 3 || ph == 5) ? 160 : 12;
      n = 0;
      while (n < 250) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 250; b++) begin
          k = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                           : 64'($urandom_range(0, kspace));
          if ($urandom_range(0, 3) == 0) k = {$urandom, 32'($urandom_range(0, 3))};
          p = $urandom;
          send(lkec_pkg::mode_e'($urandom_range(0, 1)), k, p, 0);
          n++;
        end
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 10)) @(posedge clk_i);
        if (ph == 2 && n > 100 && n < 110) drain();
      end
    end

    stall_en = 1'b1;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0 && pending_rsps.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lkec_pkg.sv
design/lkec_req_if.sv
design/lkec_dp.sv
design/lkec_ctrl.sv
design/lru_keyed_entry_cache_top.sv
design/lkec_checker.sv
bench/lru_keyed_entry_cache_top_test.sv
